// ===== rtl/ltmf_pkg.sv =====
// shared types, constants and coefficient table of the laws texture mask filter
package ltmf_pkg;

   // frame limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;

   // field and counter widths
   localparam int CFG_W   = 11;
   localparam int SEL_W   = 3;
   localparam int IDX_W   = 3;
   localparam int PIX_W   = 8;
   localparam int CNT_W   = 21;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int TAPS    = 5;
   localparam int LINES   = TAPS - 1;
   localparam int LINE_W  = LINES * PIX_W;
   localparam int PSUM_W  = 13;
   localparam int SUM_W   = 17;
   localparam int COEF_W  = 4;

   localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
   localparam logic [CFG_W-1:0] MAX_W_DIM  = CFG_W'(MAX_WIDTH);
   localparam logic [CFG_W-1:0] MAX_H_DIM  = CFG_W'(MAX_HEIGHT);

   // response queue
   localparam int FIFO_DEPTH = 8;
   localparam int FPTR_W     = $clog2(FIFO_DEPTH);
   localparam int FCNT_W     = FPTR_W + 1;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_ROW_SEL = 3'd0;
   localparam logic [IDX_W-1:0] CSR_COL_SEL = 3'd1;
   localparam logic [IDX_W-1:0] CSR_WIDTH   = 3'd2;
   localparam logic [IDX_W-1:0] CSR_HEIGHT  = 3'd3;
   localparam logic [IDX_W-1:0] CSR_ABS     = 3'd4;

   // vector codes
   localparam logic [SEL_W-1:0] VEC_W5 = 3'd4;

   // item kinds
   localparam logic KIND_PIXEL = 1'b0;

   // laws vectors L5, E5, S5, R5, W5
   localparam logic signed [COEF_W-1:0] LAWS_VEC [TAPS][TAPS] = '{
      '{ 4'sd1,  4'sd4, 4'sd6,  4'sd4,  4'sd1},
      '{-4'sd1, -4'sd2, 4'sd0,  4'sd2,  4'sd1},
      '{-4'sd1,  4'sd0, 4'sd2,  4'sd0, -4'sd1},
      '{ 4'sd1, -4'sd4, 4'sd6, -4'sd4,  4'sd1},
      '{-4'sd1,  4'sd2, 4'sd0, -4'sd2,  4'sd1}
   };

   typedef struct packed {
      logic             kind;
      logic [PIX_W-1:0] pixel_value;
   } ltmf_req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] filtered_value;
      logic                    last_of_frame;
   } ltmf_rsp_type;

   // per-item control carried down the pipeline
   typedef struct packed {
      logic            produce;
      logic            last;
      logic [TAPS-1:0] row_mask;
      logic [TAPS-1:0] col_mask;
   } ltmf_ctl_type;

   // occupancy of the arithmetic stages
   typedef struct packed {
      logic s2_busy;
      logic s3_busy;
   } ltmf_mac_status_type;

   // coefficient k of the selected vector, codes above four pick W5
   function automatic logic signed [COEF_W-1:0] laws_coef(input logic [SEL_W-1:0] sel,
                                                        input logic [SEL_W-1:0] k);
      logic [SEL_W-1:0] s;
      s = (sel > VEC_W5) ? VEC_W5 : sel;
      return LAWS_VEC[s][k];
   endfunction

endpackage

// ===== rtl/ltmf_ram.sv =====
// generic single-write, single-read ram with registered read data
module ltmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ltmf_rem_unit.sv =====
// bit-serial remainder of the item count by the image width
module ltmf_rem_unit
   import ltmf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] dividend,
   input  logic [CFG_W-1:0] divisor,
   output logic             busy,
   output logic             done,
   output logic [COL_W-1:0] remainder
);

   localparam int STEP_W = $clog2(CNT_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CNT_W - 1);

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  num_ff, num_in;
   logic [CFG_W-1:0]  rem_ff, rem_in;
   logic [CFG_W:0]    trial;

   // one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, num_ff[CNT_W-1]};
      busy_in = busy_ff;
      step_in = step_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         num_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in  = {num_ff[CNT_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = CFG_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[CFG_W-1:0];
         end
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign busy      = busy_ff;
   assign done      = busy_ff && !start && (step_ff == LAST_STEP);
   assign remainder = rem_in[COL_W-1:0];

endmodule

// ===== rtl/ltmf_window_mac.sv =====
// 5x5 pixel window and separable mask arithmetic
module ltmf_window_mac
   import ltmf_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          col_valid,
   input  logic [TAPS-1:0][PIX_W-1:0]    col_pixels,
   input  ltmf_ctl_type                  col_ctl,
   input  logic [SEL_W-1:0]              row_sel,
   input  logic [SEL_W-1:0]              col_sel,
   input  logic                          abs_en,
   output logic                          push,
   output ltmf_rsp_type                  push_data,
   output ltmf_mac_status_type           status
);

   logic [PIX_W-1:0]        win_ff [TAPS][TAPS];
   logic                    s2_valid_ff;
   ltmf_ctl_type            s2_ctl_ff;
   logic                    s3_valid_ff;
   logic                    s3_last_ff;
   logic signed [PSUM_W-1:0] srow_ff [TAPS];
   logic signed [PSUM_W-1:0] srow_in [TAPS];
   logic signed [PSUM_W-1:0] term;
   logic signed [SUM_W-1:0]  total;
   logic signed [SUM_W-1:0]  rterm;

   // window shift, newest column enters on the right
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < TAPS; a++) begin
            for (int b = 0; b < TAPS; b++) begin
               win_ff[a][b] <= '0;
            end
         end
      end else if (col_valid) begin
         for (int a = 0; a < TAPS; a++) begin
            for (int b = 0; b < TAPS - 1; b++) begin
               win_ff[a][b] <= win_ff[a][b+1];
            end
            win_ff[a][TAPS-1] <= col_pixels[a];
         end
      end
   end

   // per-row column-weighted sums
   always_comb begin
      term = '0;
      for (int a = 0; a < TAPS; a++) begin
         srow_in[a] = '0;
         for (int b = 0; b < TAPS; b++) begin
            term = PSUM_W'($signed({1'b0, win_ff[a][b]}))
                 * PSUM_W'(laws_coef(col_sel, SEL_W'(b)));
            if (s2_ctl_ff.col_mask[b]) begin
               srow_in[a] = srow_in[a] + term;
            end
         end
         if (!s2_ctl_ff.row_mask[a]) begin
            srow_in[a] = '0;
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= col_valid && col_ctl.produce;
         s3_valid_ff <= s2_valid_ff;
      end
      s2_ctl_ff  <= col_ctl;
      s3_last_ff <= s2_ctl_ff.last;
      for (int a = 0; a < TAPS; a++) begin
         srow_ff[a] <= srow_in[a];
      end
   end

   // row-weighted total and optional magnitude
   always_comb begin
      total = '0;
      rterm = '0;
      for (int a = 0; a < TAPS; a++) begin
         rterm = SUM_W'(srow_ff[a]) * SUM_W'(laws_coef(row_sel, SEL_W'(a)));
         total = total + rterm;
      end
      if (abs_en && total[SUM_W-1]) begin
         total = -total;
      end
   end

   assign push                     = s3_valid_ff;
   assign push_data.filtered_value = total;
   assign push_data.last_of_frame  = s3_last_ff;
   assign status.s2_busy           = s2_valid_ff;
   assign status.s3_busy           = s3_valid_ff;

endmodule

// ===== rtl/ltmf_rsp_fifo.sv =====
// small response queue between the arithmetic stages and the result channel
module ltmf_rsp_fifo
   import ltmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ltmf_rsp_type      push_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ltmf_rsp_type      rsp_data,
   output logic [FCNT_W-1:0] count
);

   ltmf_rsp_type      slot_ff [FIFO_DEPTH];
   logic [FPTR_W-1:0] wr_ptr_ff;
   logic [FPTR_W-1:0] rd_ptr_ff;
   logic [FCNT_W-1:0] count_ff;
   logic              pop;

   assign pop = rsp_valid && rsp_ready;

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

// ===== rtl/laws_texture_mask_filter_top.sv =====
// top level of the laws texture mask filter
//
// Takes one request per clock when not stalled and returns the 5x5 laws mask response
// of each raster position 2*width+2 requests after its pixel, through the read-back
// stage, the arithmetic stages and the response queue. Four image lines sit side by
// side in one line-store ram, one word per column, read at request acceptance and
// written back the next cycle with the column shifted up (a same-column read in that
// cycle is forwarded). After reset a clearing pass zeroes all MAX_WIDTH (1024) line-store
// words before the first request is taken. A write of the width register stalls requests
// while a bit-serial unit recomputes the column from the item count. Requests also wait
// when the eight-entry response queue and the results in flight would exceed its room.
module laws_texture_mask_filter_top
   import ltmf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ltmf_req_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ltmf_rsp_type       rsp_data,
   input  logic               csr_write_en,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [CFG_W-1:0]   csr_wdata
);

   // configuration registers
   logic [SEL_W-1:0] row_sel_ff;
   logic [SEL_W-1:0] col_sel_ff;
   logic [CFG_W-1:0] width_ff;
   logic [CFG_W-1:0] height_ff;
   logic             abs_ff;

   // stream counters
   logic [CNT_W-1:0] items_ff, items_in;
   logic [COL_W-1:0] x_ff, x_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;

   // clearing pass
   logic             clear_ff;
   logic [COL_W-1:0] clr_addr_ff;

   // read-back stage
   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_addr_ff;
   logic [PIX_W-1:0] s1_px_ff;
   ltmf_ctl_type     s1_ctl_ff;
   logic             fwd_ff;
   logic [LINE_W-1:0] fwd_data_ff;

   logic [CFG_W-1:0] w_eff, h_eff;
   logic [CFG_W:0]   col_next, row_lim, col_lim;
   logic [CFG_W:0]   tap_pos;
   logic             accept;
   logic             produce, last;
   ltmf_ctl_type     ctl;
   logic [PIX_W-1:0] px;
   logic [LINE_W-1:0] ram_rd, col_word, wb_word;
   logic             ram_we;
   logic [COL_W-1:0] ram_wa;
   logic [LINE_W-1:0] ram_wd;
   logic [TAPS-1:0][PIX_W-1:0] col_pixels;
   logic             rem_start, rem_busy, rem_done;
   logic [COL_W-1:0] rem_value;
   logic             mac_push;
   ltmf_rsp_type     mac_data;
   ltmf_mac_status_type mac_status;
   logic [FCNT_W-1:0] fifo_count;
   logic [FCNT_W-1:0] pending;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         row_sel_ff <= '0;
         col_sel_ff <= '0;
         width_ff   <= MAX_W_DIM;
         height_ff  <= MAX_H_DIM;
         abs_ff     <= 1'b1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROW_SEL: row_sel_ff <= csr_wdata[SEL_W-1:0];
            CSR_COL_SEL: col_sel_ff <= csr_wdata[SEL_W-1:0];
            CSR_WIDTH:   width_ff   <= csr_wdata;
            CSR_HEIGHT:  height_ff  <= csr_wdata;
            CSR_ABS:     abs_ff     <= csr_wdata[0];
            default:     ;
         endcase
      end
   end

   // effective frame size
   always_comb begin
      w_eff = (width_ff == '0) ? CFG_W'(1) : ((width_ff > MAX_W_DIM) ? MAX_W_DIM : width_ff);
      h_eff = (height_ff == '0) ? CFG_W'(1) : ((height_ff > MAX_H_DIM) ? MAX_H_DIM : height_ff);
   end

   // request admission
   assign pending   = fifo_count + FCNT_W'(s1_valid_ff && s1_ctl_ff.produce)
                    + FCNT_W'(mac_status.s2_busy) + FCNT_W'(mac_status.s3_busy);
   assign req_ready = !clear_ff && !rem_busy && (pending < FCNT_W'(FIFO_DEPTH));
   assign accept    = req_valid && req_ready;

   // position decode of the incoming item
   always_comb begin
      produce = (items_ff >= (CNT_W'({w_eff, 1'b0}) + CNT_W'(2)));
      last    = produce && ({1'b0, out_row_ff} >= CFG_W'(h_eff - 1'b1))
                        && ({1'b0, out_col_ff} >= CFG_W'(w_eff - 1'b1));
      row_lim = {1'b0, h_eff} + (CFG_W+1)'(2);
      col_lim = {1'b0, w_eff} + (CFG_W+1)'(2);
      ctl.produce = produce;
      ctl.last    = last;
      tap_pos     = '0;
      for (int a = 0; a < TAPS; a++) begin
         tap_pos         = (CFG_W+1)'(out_row_ff) + (CFG_W+1)'(a);
         ctl.row_mask[a] = (tap_pos >= (CFG_W+1)'(2)) && (tap_pos < row_lim);
         tap_pos         = (CFG_W+1)'(out_col_ff) + (CFG_W+1)'(a);
         ctl.col_mask[a] = (tap_pos >= (CFG_W+1)'(2)) && (tap_pos < col_lim);
      end
   end

   // counter advance
   always_comb begin
      items_in   = items_ff;
      x_in       = x_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      col_next   = (CFG_W+1)'(out_col_ff) + 1'b1;
      if (rem_done) begin
         x_in = rem_value;
      end else if (accept) begin
         if (last) begin
            items_in   = '0;
            x_in       = '0;
            out_row_in = '0;
            out_col_in = '0;
         end else begin
            if (items_ff != CNT_MAX) begin
               items_in = items_ff + 1'b1;
               if (((CFG_W+1)'(x_ff) + 1'b1) >= {1'b0, w_eff}) begin
                  x_in = '0;
               end else begin
                  x_in = x_ff + 1'b1;
               end
            end
            if (produce) begin
               if (col_next >= {1'b0, w_eff}) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + 1'b1;
               end else begin
                  out_col_in = col_next[COL_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff   <= '0;
         x_ff       <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else begin
         items_ff   <= items_in;
         x_ff       <= x_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
      end
   end

   // line store clearing after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clear_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == COL_W'(MAX_WIDTH - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // read-back stage registers and same-column forwarding
   assign px = (req_data.kind == KIND_PIXEL) ? req_data.pixel_value : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         fwd_ff      <= accept && s1_valid_ff && (s1_addr_ff == x_ff);
      end
      s1_addr_ff  <= x_ff;
      s1_px_ff    <= px;
      s1_ctl_ff   <= ctl;
      fwd_data_ff <= wb_word;
   end

   // column assembly and write-back word
   always_comb begin
      col_word      = fwd_ff ? fwd_data_ff : ram_rd;
      wb_word       = {col_word[LINE_W-PIX_W-1:0], s1_px_ff};
      col_pixels[0] = col_word[4*PIX_W-1:3*PIX_W];
      col_pixels[1] = col_word[3*PIX_W-1:2*PIX_W];
      col_pixels[2] = col_word[2*PIX_W-1:PIX_W];
      col_pixels[3] = col_word[PIX_W-1:0];
      col_pixels[4] = s1_px_ff;
      ram_we        = clear_ff || s1_valid_ff;
      ram_wa        = clear_ff ? clr_addr_ff : s1_addr_ff;
      ram_wd        = clear_ff ? '0 : wb_word;
   end

   ltmf_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (accept),
      .rd_addr (x_ff),
      .rd_data (ram_rd)
   );

   // column recompute after a width change
   assign rem_start = csr_write_en && (csr_index == CSR_WIDTH);

   ltmf_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (items_ff),
      .divisor   (w_eff),
      .busy      (rem_busy),
      .done      (rem_done),
      .remainder (rem_value)
   );

   ltmf_window_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .col_valid  (s1_valid_ff),
      .col_pixels (col_pixels),
      .col_ctl    (s1_ctl_ff),
      .row_sel    (row_sel_ff),
      .col_sel    (col_sel_ff),
      .abs_en     (abs_ff),
      .push       (mac_push),
      .push_data  (mac_data),
      .status     (mac_status)
   );

   ltmf_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mac_push),
      .push_data (mac_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .count     (fifo_count)
   );

endmodule

// ===== tb/laws_texture_mask_filter_top_tb.sv =====
// self-checking testbench for the laws texture mask filter top level
`timescale 1ns / 1ps

module laws_texture_mask_filter_top_tb;
   import ltmf_pkg::*;

   // vector selector codes beside the packaged W5 code
   localparam logic [SEL_W-1:0] VEC_L5     = 3'd0;
   localparam logic [SEL_W-1:0] VEC_S5     = 3'd2;
   localparam logic [SEL_W-1:0] VEC_R5     = 3'd3;
   localparam logic [SEL_W-1:0] VEC_BEYOND = 3'd7;
   localparam logic             KIND_FLUSH = ~KIND_PIXEL;

   localparam int          ITEM_BUDGET  = 1800;
   localparam int          SPLIT_MAX    = 256;
   localparam int          DRAIN_CYCLES = 16;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;

   // laws vectors L5, E5, S5, R5, W5 for the mask predictor
   localparam int MASK_VECTORS [TAPS][TAPS] = '{
      '{ 1,  4, 6,  4,  1},
      '{-1, -2, 0,  2,  1},
      '{-1,  0, 2,  0, -1},
      '{ 1, -4, 6, -4,  1},
      '{-1,  2, 0, -2,  1}
   };

   // one-pixel frames whose response is the center tap alone
   typedef struct packed {
      logic [SEL_W-1:0]        row_sel;
      logic [SEL_W-1:0]        col_sel;
      logic [CFG_W-1:0]        width;
      logic [CFG_W-1:0]        height;
      logic                    abs_on;
      logic                    head_kind;
      logic [PIX_W-1:0]        head_pixel;
      logic                    tail_kind;
      logic signed [SUM_W-1:0] want;
   } probe_row_type;

   localparam probe_row_type PROBES [5] = '{
      '{VEC_L5, VEC_L5, 11'd0, 11'd0, 1'b1, KIND_PIXEL, 8'd255, KIND_FLUSH, 17'sd9180},
      '{VEC_R5, VEC_R5, 11'd1, 11'd1, 1'b0, KIND_PIXEL, 8'd128, KIND_FLUSH, 17'sd4608},
      '{VEC_S5, VEC_L5, 11'd1, 11'd1, 1'b1, KIND_PIXEL, 8'd255, KIND_PIXEL, 17'sd3060},
      '{VEC_BEYOND, VEC_W5, 11'd1, 11'd1, 1'b1, KIND_PIXEL, 8'd200, KIND_FLUSH, 17'sd0},
      '{VEC_L5, VEC_R5, 11'd1, 11'd1, 1'b1, KIND_FLUSH, 8'd255, KIND_FLUSH, 17'sd0}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   ltmf_req_type       req_data;
   logic               rsp_valid;
   logic               rsp_ready;
   ltmf_rsp_type       rsp_data;
   logic               csr_write_en;
   logic [IDX_W-1:0]   csr_index;
   logic [CFG_W-1:0]   csr_wdata;

   // register mirror and filter state of the predictor
   bit [SEL_W-1:0]   row_sel_q;
   bit [SEL_W-1:0]   col_sel_q;
   bit [CFG_W-1:0]   width_q;
   bit [CFG_W-1:0]   height_q;
   bit               abs_q;
   logic [PIX_W-1:0] line_mem [LINES][MAX_WIDTH];
   logic [PIX_W-1:0] patch [TAPS][TAPS];
   int unsigned      taken;
   int               out_row;
   int               out_col;

   ltmf_rsp_type     due_responses [$];
   ltmf_rsp_type     oldest_due;
   int               mismatches;
   int               streamed_items;
   int unsigned      cycle_count;
   bit               calm;

   laws_texture_mask_filter_top DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // effective frame size: zero reads as one, large values saturate
   function automatic int frame_dim(input bit [CFG_W-1:0] raw, input int limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return raw;
   endfunction

   // idle length, mostly none, a few long
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
      mismatches++;
   endtask

   // shift one request into the line store and window, return the mask response if due
   task automatic laws_convolve(input ltmf_req_type item, output bit produced,
                                output ltmf_rsp_type result);
      int               w, h, x, rr, cc, a, b, total, rv, cv;
      logic [PIX_W-1:0] column [TAPS];
      logic [PIX_W-1:0] pix;
      bit               last;
      w = frame_dim(width_q, MAX_WIDTH);
      h = frame_dim(height_q, MAX_HEIGHT);
      x = taken % w;
      pix = (item.kind == KIND_PIXEL) ? item.pixel_value : '0;
      // oldest line at the top of the column
      for (a = 0; a < LINES; a++) column[a] = line_mem[LINES-1-a][x];
      column[LINES] = pix;
      for (a = LINES - 1; a > 0; a--) line_mem[a][x] = line_mem[a-1][x];
      line_mem[0][x] = pix;
      for (a = 0; a < TAPS; a++) begin
         for (b = 0; b < TAPS - 1; b++) patch[a][b] = patch[a][b+1];
         patch[a][TAPS-1] = column[a];
      end
      produced = 1'b0;
      result = '0;
      if (taken < 2 * w + 2) begin
         if (taken < CNT_MAX) taken++;
      end else begin
         rv = (row_sel_q > VEC_W5) ? VEC_W5 : row_sel_q;
         cv = (col_sel_q > VEC_W5) ? VEC_W5 : col_sel_q;
         total = 0;
         // taps outside the frame count as zero
         for (a = 0; a < TAPS; a++) begin
            rr = out_row + a - 2;
            if (rr >= 0 && rr < h) begin
               for (b = 0; b < TAPS; b++) begin
                  cc = out_col + b - 2;
                  if (cc >= 0 && cc < w)
                     total += int'(patch[a][b]) * MASK_VECTORS[rv][a] * MASK_VECTORS[cv][b];
               end
            end
         end
         if (abs_q && total < 0) total = -total;
         last = (out_row >= h - 1) && (out_col >= w - 1);
         result.filtered_value = total[SUM_W-1:0];
         result.last_of_frame = last;
         produced = 1'b1;
         // advance the output position, the last one restarts the frame
         if (last) begin
            taken = 0;
            out_row = 0;
            out_col = 0;
         end else begin
            if (taken < CNT_MAX) taken++;
            if (out_col + 1 >= w) begin
               out_col = 0;
               out_row = (out_row + 1) & (MAX_HEIGHT - 1);
            end else begin
               out_col = (out_col + 1) & (MAX_WIDTH - 1);
            end
         end
      end
   endtask

   // present one request after a random gap, return at the falling edge after acceptance
   task automatic send_request(input ltmf_req_type item);
      int gap;
      gap = pick_pause();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // hold off requests until every response is back and the pipeline is empty
   task automatic settle();
      req_valid <= 1'b0;
      while (due_responses.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   // write the registers whose value changes
   task automatic program_filter(input bit [SEL_W-1:0] rs, input bit [SEL_W-1:0] cs,
                                 input bit [CFG_W-1:0] wd, input bit [CFG_W-1:0] ht,
                                 input bit ab);
      if (rs != row_sel_q) write_csr(CSR_ROW_SEL, CFG_W'(rs));
      if (cs != col_sel_q) write_csr(CSR_COL_SEL, CFG_W'(cs));
      if (wd != width_q) write_csr(CSR_WIDTH, wd);
      if (ht != height_q) write_csr(CSR_HEIGHT, ht);
      if (ab != abs_q) write_csr(CSR_ABS, CFG_W'(ab));
      csr_write_en <= 1'b0;
      row_sel_q = rs;
      col_sel_q = cs;
      width_q = wd;
      height_q = ht;
      abs_q = ab;
   endtask

   // one frame: pixels then flush requests, with a little of each kind out of place
   task automatic stream_frame(input bit interrupt);
      ltmf_req_type item;
      ltmf_rsp_type predicted;
      bit           produced, done;
      int           npix, span, split, idx, r;
      npix = frame_dim(width_q, MAX_WIDTH) * frame_dim(height_q, MAX_HEIGHT);
      span = npix + 2 * frame_dim(width_q, MAX_WIDTH) + 1;
      // wide frames are cut short early
      if (span > SPLIT_MAX) span = SPLIT_MAX;
      split = interrupt ? $urandom_range(1, span) : -1;
      idx = 0;
      done = 1'b0;
      while (!done) begin
         // reconfigure in the middle of the frame once the pipeline is drained
         if (idx == split) begin
            settle();
            program_filter(SEL_W'($urandom_range(0, 7)), SEL_W'($urandom_range(0, 7)),
                           CFG_W'($urandom_range(1, 8)), CFG_W'($urandom_range(1, 8)),
                           1'($urandom_range(0, 1)));
         end
         r = $urandom_range(0, 15);
         if (idx < npix) item.kind = (r == 0) ? KIND_FLUSH : KIND_PIXEL;
         else item.kind = (r == 0) ? KIND_PIXEL : KIND_FLUSH;
         r = $urandom_range(0, 9);
         item.pixel_value = (r == 0) ? '0 : (r == 1) ? '1 : PIX_W'($urandom);
         laws_convolve(item, produced, predicted);
         if (produced) due_responses.push_back(predicted);
         done = produced && predicted.last_of_frame;
         send_request(item);
         idx++;
         streamed_items++;
      end
   endtask

   // response backpressure
   initial begin : rsp_side
      int hold;
      rsp_ready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = pick_pause();
         end
      end
   end

   // compare each response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_responses.size() == 0) begin
            report_mismatch("response with none pending", $signed(rsp_data.filtered_value), 0);
         end else begin
            oldest_due = due_responses.pop_front();
            if (rsp_data.filtered_value !== oldest_due.filtered_value)
               report_mismatch("filtered_value", $signed(rsp_data.filtered_value),
                               $signed(oldest_due.filtered_value));
            if (rsp_data.last_of_frame !== oldest_due.last_of_frame)
               report_mismatch("last_of_frame", rsp_data.last_of_frame,
                               oldest_due.last_of_frame);
         end
      end
   end

   // run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("laws_texture_mask_filter_top_tb: done, errors");
      $finish;
   end

   // stimulus
   initial begin
      ltmf_req_type item;
      ltmf_rsp_type predicted, typed_rsp;
      bit           produced;
      int           i, k, a, b, wd;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      calm = 1'b0;
      mismatches = 0;
      streamed_items = 0;
      row_sel_q = VEC_L5;
      col_sel_q = VEC_L5;
      width_q = MAX_W_DIM;
      height_q = MAX_H_DIM;
      abs_q = 1'b1;
      taken = 0;
      out_row = 0;
      out_col = 0;
      for (a = 0; a < LINES; a++)
         for (b = 0; b < MAX_WIDTH; b++) line_mem[a][b] = '0;
      for (a = 0; a < TAPS; a++)
         for (b = 0; b < TAPS; b++) patch[a][b] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed one-pixel frames with responses typed in
      for (i = 0; i < 5; i++) begin
         settle();
         program_filter(PROBES[i].row_sel, PROBES[i].col_sel, PROBES[i].width,
                        PROBES[i].height, PROBES[i].abs_on);
         for (k = 0; k < 5; k++) begin
            item.kind = (k == 0) ? PROBES[i].head_kind : PROBES[i].tail_kind;
            item.pixel_value = (k == 0) ? PROBES[i].head_pixel : 8'hFF;
            laws_convolve(item, produced, predicted);
            if (produced) begin
               typed_rsp.filtered_value = PROBES[i].want;
               typed_rsp.last_of_frame = 1'b1;
               due_responses.push_back(typed_rsp);
            end
            send_request(item);
            streamed_items++;
         end
      end

      // widest frame from a saturated width and a zero height, cut short by a reconfiguration
      settle();
      calm = 1'($urandom_range(0, 1));
      program_filter(SEL_W'($urandom_range(0, 7)), SEL_W'($urandom_range(0, 7)),
                     11'h7FF, 11'd0, 1'($urandom_range(0, 1)));
      stream_frame(1'b1);

      // tallest frame, one pixel wide
      settle();
      calm = 1'($urandom_range(0, 1));
      program_filter(SEL_W'($urandom_range(0, 7)), SEL_W'($urandom_range(0, 7)),
                     11'd1, 11'h7FF, 1'($urandom_range(0, 1)));
      stream_frame(1'b0);

      // random frames, mostly small
      while (streamed_items < ITEM_BUDGET) begin
         settle();
         calm = ($urandom_range(0, 3) == 0);
         wd = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         if ($urandom_range(0, 19) == 0) wd = 0;
         program_filter(SEL_W'($urandom_range(0, 7)), SEL_W'($urandom_range(0, 7)),
                        CFG_W'(wd),
                        CFG_W'((wd > 12) ? $urandom_range(1, 3) : $urandom_range(0, 12)),
                        1'($urandom_range(0, 1)));
         stream_frame($urandom_range(0, 5) == 0);
      end

      // drain and finish
      req_valid <= 1'b0;
      while (due_responses.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && due_responses.size() == 0)
         $display("laws_texture_mask_filter_top_tb: done, clean");
      else
         $display("laws_texture_mask_filter_top_tb: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/ltmf_pkg.sv
rtl/ltmf_ram.sv
rtl/ltmf_rem_unit.sv
rtl/ltmf_window_mac.sv
rtl/ltmf_rsp_fifo.sv
rtl/laws_texture_mask_filter_top.sv
tb/laws_texture_mask_filter_top_tb.sv
